>>> design/cdq_pkg.sv
`default_nettype none
package cdq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int CAP_W     = 5;
  localparam int DATA_W    = 32;
  localparam int FUNC_W    = 3;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;
  localparam logic [PADDR_W-1:0] ADDR_CAP  = 3'd0;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_REAR  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_REAR   = 3'd3,
    FN_PEEK_FRONT = 3'd4,
    FN_PEEK_REAR  = 3'd5
  } cdq_func_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } cdq_state_t;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] data;
    logic              now_empty;
    logic              now_full;
  } cdq_res_t;

endpackage
`default_nettype wire

>>> design/cdq_ram.sv
`default_nettype none
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> design/cdq_ctrl.sv
`default_nettype none
module cdq_ctrl
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [CAP_W-1:0]  capacity,
  input  wire logic              clear,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire logic [FUNC_W-1:0] req_func,
  input  wire logic [DATA_W-1:0] req_value,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output cdq_res_t               res
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cdq_state_t state_r, state_nxt;
  logic [IW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic          empty_r, empty_nxt;

  logic [CW-1:0]     cap_c;
  logic [31:0]       cap32;
  logic [IW-1:0]     hn, tn;
  logic              full_cur;
  logic              accept;
  logic              need_read;
  logic              imm_ok;
  logic [DATA_W-1:0] imm_data;
  logic              we;
  logic [IW-1:0]     waddr;
  logic              re;
  logic [IW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;

  function automatic logic [IW-1:0] up_f(input logic [IW-1:0] i, input logic [CW-1:0] c);
    logic [31:0] n;
    n = 32'(i) + 32'd1;
    up_f = (n >= 32'(c)) ? '0 : n[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] down_f(input logic [IW-1:0] i, input logic [CW-1:0] c);
    logic [31:0] m;
    m = 32'(c) - 32'd1;
    down_f = (i == '0) ? m[IW-1:0] : i - {{(IW-1){1'b0}}, 1'b1};
  endfunction

  // capacity clamped to 2..DEPTH, the slots that exist
  always_comb begin
    cap32 = {{(32-CAP_W){1'b0}}, capacity};
    if (cap32 < 32'd2) begin
      cap32 = 32'd2;
    end else if (cap32 > 32'(DEPTH)) begin
      cap32 = 32'(DEPTH);
    end
    cap_c = cap32[CW-1:0];
  end

  assign hn       = (32'(head_r) >= 32'(cap_c)) ? '0 : head_r;
  assign tn       = (32'(tail_r) >= 32'(cap_c)) ? '0 : tail_r;
  assign full_cur = !empty_r && (up_f(tn, cap_c) == hn);
  assign accept   = req_valid && req_ready;

  // index update and memory access for the accepted transaction, or index reset on clear
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    empty_nxt = empty_r;
    need_read = 1'b0;
    imm_ok    = 1'b0;
    imm_data  = '1;
    we        = 1'b0;
    waddr     = '0;
    re        = 1'b0;
    raddr     = hn;
    if (clear) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      empty_nxt = 1'b1;
    end else if (accept) begin
      head_nxt = hn;
      tail_nxt = tn;
      case (req_func)
        FN_PUSH_FRONT, FN_PUSH_REAR: begin
          if (!full_cur) begin
            imm_ok   = 1'b1;
            imm_data = req_value;
            we       = 1'b1;
            if (empty_r) begin
              head_nxt  = '0;
              tail_nxt  = '0;
              empty_nxt = 1'b0;
              waddr     = '0;
            end else if (req_func == FN_PUSH_FRONT) begin
              head_nxt = down_f(hn, cap_c);
              waddr    = head_nxt;
            end else begin
              tail_nxt = up_f(tn, cap_c);
              waddr    = tail_nxt;
            end
          end
        end
        FN_POP_FRONT, FN_POP_REAR: begin
          if (!empty_r) begin
            need_read = 1'b1;
            re        = 1'b1;
            raddr     = (req_func == FN_POP_FRONT) ? hn : tn;
            if (hn == tn) begin
              head_nxt  = '0;
              tail_nxt  = '0;
              empty_nxt = 1'b1;
            end else if (req_func == FN_POP_FRONT) begin
              head_nxt = up_f(hn, cap_c);
            end else begin
              tail_nxt = down_f(tn, cap_c);
            end
          end
        end
        FN_PEEK_FRONT, FN_PEEK_REAR: begin
          if (!empty_r) begin
            need_read = 1'b1;
            re        = 1'b1;
            raddr     = (req_func == FN_PEEK_FRONT) ? hn : tn;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && need_read) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready     = 1'b0;
    res_valid     = 1'b0;
    res.ok        = imm_ok;
    res.data      = imm_data;
    res.now_empty = empty_nxt;
    res.now_full  = !empty_nxt && (up_f(tail_nxt, cap_c) == head_nxt);
    case (state_r)
      ST_IDLE: begin
        req_ready = res_ready;
        res_valid = accept && !need_read;
      end
      ST_READ: begin
        res_valid = 1'b1;
        res.ok    = 1'b1;
        res.data  = rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

  cdq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(req_value),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

endmodule
`default_nettype wire

>>> design/circular_deque.sv
// Double-ended queue of 32-bit words in a circular store of DEPTH slots, of which
// the first capacity (register at address 0, saturated to 2..DEPTH) are in use.
// in_tuser selects the operation (push front/rear, pop front/rear, peek front/rear),
// in_tdata carries the word to push. Each request gives one result: out_tuser is the
// success flag, out_tdata holds the word (all ones on failure) and the empty and full
// flags after the request. A push or failed request goes to the output register when
// accepted; a successful pop or peek waits in a read state for the registered RAM read.
// Writing capacity empties the queue; write it only while no request is in flight.
`default_nettype none
module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [DATA_W-1:0]  in_tdata,   // value[31:0]
  input  wire logic [FUNC_W-1:0]  in_tuser,   // func[2:0]
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [39:0]             out_tdata,  // data[31:0], now_empty[32], now_full[33]
  output logic                    out_tuser,  // ok[0]
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [PADDR_W-1:0] cfg_paddr,
  input  wire logic [PDATA_W-1:0] cfg_pwdata,
  output logic      [PDATA_W-1:0] cfg_prdata,
  output logic                    cfg_pready
);

  logic [CAP_W-1:0] capacity_r;
  logic             cap_wr;
  logic             out_valid_r;
  cdq_res_t         out_res_r;
  logic             res_valid;
  logic             res_ready;
  cdq_res_t         res;

  assign cfg_pready = 1'b1;
  assign cap_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == ADDR_CAP);
  assign cfg_prdata = (cfg_paddr == ADDR_CAP) ? {{(PDATA_W-CAP_W){1'b0}}, capacity_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cap_wr) begin
      capacity_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  cdq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .capacity (capacity_r),
    .clear    (cap_wr),
    .req_valid(in_tvalid),
    .req_ready(in_tready),
    .req_func (in_tuser),
    .req_value(in_tdata),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // output register, free when empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.ok;
  assign out_tdata  = {6'd0, out_res_r.now_full, out_res_r.now_empty, out_res_r.data};

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[32] && out_tdata[33]))
    else $error("queue reported empty and full at once");

  a_fail_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[31:0] == '1)
    else $error("failed transaction without all-ones data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result transaction changed while stalled");

endmodule
`default_nettype wire

>>> tb/circular_deque_tb.sv
`timescale 1ns / 1ps
module circular_deque_tb;
  import cdq_pkg::*;

  // selector codes that the block must treat as no-ops
  localparam logic [FUNC_W-1:0] FN_UNUSED_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_UNUSED_7 = 3'd7;

  localparam logic [DATA_W-1:0] WORD_NEG_ONE = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] WORD_MIN     = 32'h8000_0000;
  localparam logic [DATA_W-1:0] WORD_MAX     = 32'h7FFF_FFFF;

  class deque_scoreboard;
    logic [DATA_W-1:0] slot_mem [DEPTH_DEF];
    int                head_idx;
    int                tail_idx;
    bit                is_empty;
    logic [CAP_W-1:0]  cap_reg;
    cdq_res_t          owed[$];
    int                errors;

    function new();
      head_idx = 0;
      tail_idx = 0;
      is_empty = 1'b1;
      cap_reg  = CAP_RESET;
      errors   = 0;
      foreach (slot_mem[i]) slot_mem[i] = '0;
    endfunction

    function void set_capacity(logic [PDATA_W-1:0] wdata);
      cap_reg  = wdata[CAP_W-1:0];
      head_idx = 0;
      tail_idx = 0;
      is_empty = 1'b1;
    endfunction

    function int slots_in_use();
      int c;
      c = int'(cap_reg);
      if (c < 2) c = 2;
      if (c > DEPTH_DEF) c = DEPTH_DEF;
      return c;
    endfunction

    function int next_idx(int i, int c);
      return (i + 1 >= c) ? 0 : i + 1;
    endfunction

    function int prev_idx(int i, int c);
      return (i == 0) ? c - 1 : i - 1;
    endfunction

    function bit is_full(int c);
      return !is_empty && next_idx(tail_idx, c) == head_idx;
    endfunction

    function void note_request(logic [FUNC_W-1:0] fn, logic [DATA_W-1:0] val);
      cdq_res_t r;
      int       c;
      c = slots_in_use();
      r.ok = 1'b0;
      r.data = WORD_NEG_ONE;
      if (head_idx >= c) head_idx = 0;
      if (tail_idx >= c) tail_idx = 0;
      case (fn)
        FN_PUSH_FRONT, FN_PUSH_REAR: begin
          if (!is_full(c)) begin
            if (is_empty) begin
              head_idx = 0;
              tail_idx = 0;
              is_empty = 1'b0;
              slot_mem[0] = val;
            end else if (fn == FN_PUSH_FRONT) begin
              head_idx = prev_idx(head_idx, c);
              slot_mem[head_idx] = val;
            end else begin
              tail_idx = next_idx(tail_idx, c);
              slot_mem[tail_idx] = val;
            end
            r.ok = 1'b1;
            r.data = val;
          end
        end
        FN_POP_FRONT, FN_POP_REAR: begin
          if (!is_empty) begin
            r.data = (fn == FN_POP_FRONT) ? slot_mem[head_idx] : slot_mem[tail_idx];
            if (head_idx == tail_idx) begin
              head_idx = 0;
              tail_idx = 0;
              is_empty = 1'b1;
            end else if (fn == FN_POP_FRONT) begin
              head_idx = next_idx(head_idx, c);
            end else begin
              tail_idx = prev_idx(tail_idx, c);
            end
            r.ok = 1'b1;
          end
        end
        FN_PEEK_FRONT, FN_PEEK_REAR: begin
          if (!is_empty) begin
            r.data = (fn == FN_PEEK_FRONT) ? slot_mem[head_idx] : slot_mem[tail_idx];
            r.ok = 1'b1;
          end
        end
        default: ;
      endcase
      r.now_empty = is_empty;
      r.now_full  = is_full(c);
      owed.push_back(r);
    endfunction

    function void check_result(logic ok, logic [DATA_W-1:0] data, logic now_empty,
                               logic now_full);
      cdq_res_t exp_res;
      if (owed.size() == 0) begin
        $error("result transaction with nothing expected (ok=%0d data=%h)", ok, data);
        errors++;
        return;
      end
      exp_res = owed.pop_front();
      if (ok !== exp_res.ok) begin
        $error("ok: expected %0d, actual %0d", exp_res.ok, ok);
        errors++;
      end
      if (data !== exp_res.data) begin
        $error("data: expected %h, actual %h", exp_res.data, data);
        errors++;
      end
      if (now_empty !== exp_res.now_empty) begin
        $error("now_empty: expected %0d, actual %0d", exp_res.now_empty, now_empty);
        errors++;
      end
      if (now_full !== exp_res.now_full) begin
        $error("now_full: expected %0d, actual %0d", exp_res.now_full, now_full);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [DATA_W-1:0]  in_tdata;
  logic [FUNC_W-1:0]  in_tuser;
  logic               out_tvalid;
  logic               out_tready;
  logic [39:0]        out_tdata;
  logic               out_tuser;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [PDATA_W-1:0] cfg_pwdata;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  deque_scoreboard sb;
  bit              pacing_on;

  circular_deque uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // receiver side: random back-pressure while pacing is on
  always @(negedge clk) begin
    out_tready <= !pacing_on || ($urandom_range(0, 99) >= 33);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tuser, out_tdata[31:0], out_tdata[32], out_tdata[33]);
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic issue_request(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] val);
    while (pacing_on && $urandom_range(0, 99) < 33) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= val;
    do @(posedge clk); while (!in_tready);
    sb.note_request(fn, val);
    @(negedge clk);
  endtask

  task automatic drain_and_settle();
    in_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(negedge clk);
    // every owed result is out, so no pop is still reading its slot; the bench idles on
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap_val);
    logic [PDATA_W-1:0] wdata;
    wdata = $urandom;
    if ($urandom_range(0, 1)) wdata = '0;
    wdata[CAP_W-1:0] = cap_val;
    drain_and_settle();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_CAP;
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_capacity(wdata);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return WORD_NEG_ONE;
      2: return WORD_MIN;
      3: return WORD_MAX;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_requests(input int count, input int push_pct, input int pop_pct);
    int                r;
    logic [FUNC_W-1:0] fn;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 5) fn = $urandom_range(0, 1) ? FN_UNUSED_7 : FN_UNUSED_6;
      else if (r < 5 + push_pct) fn = $urandom_range(0, 1) ? FN_PUSH_REAR : FN_PUSH_FRONT;
      else if (r < 5 + push_pct + pop_pct)
        fn = $urandom_range(0, 1) ? FN_POP_REAR : FN_POP_FRONT;
      else fn = $urandom_range(0, 1) ? FN_PEEK_REAR : FN_PEEK_FRONT;
      issue_request(fn, pick_word());
    end
  endtask

  initial begin
    logic [CAP_W-1:0] cap_plan [8];
    sb = new();
    pacing_on   = 1'b1;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty queue, unused selectors, extremes, both ends, drain to empty
    issue_request(FN_PEEK_FRONT, WORD_NEG_ONE);
    issue_request(FN_PEEK_REAR, '0);
    issue_request(FN_POP_FRONT, WORD_MAX);
    issue_request(FN_POP_REAR, WORD_MIN);
    issue_request(FN_UNUSED_6, WORD_NEG_ONE);
    issue_request(FN_PUSH_FRONT, WORD_MIN);
    issue_request(FN_PUSH_REAR, WORD_MAX);
    issue_request(FN_PUSH_FRONT, '0);
    issue_request(FN_PUSH_REAR, WORD_NEG_ONE);
    issue_request(FN_UNUSED_7, WORD_MAX);
    issue_request(FN_PEEK_FRONT, '0);
    issue_request(FN_PEEK_REAR, '0);
    issue_request(FN_POP_REAR, '0);
    issue_request(FN_POP_FRONT, '0);
    issue_request(FN_POP_FRONT, '0);
    issue_request(FN_POP_REAR, '0);
    issue_request(FN_POP_FRONT, '0);

    // smallest queue: wrap at the front, push into a full queue
    write_capacity(5'd2);
    issue_request(FN_PUSH_REAR, 32'h1234_5678);
    issue_request(FN_PUSH_FRONT, 32'hCAFE_F00D);
    issue_request(FN_PUSH_FRONT, 32'h5555_5555);
    issue_request(FN_PUSH_REAR, 32'hAAAA_AAAA);
    issue_request(FN_PEEK_FRONT, '0);
    issue_request(FN_POP_REAR, '0);
    issue_request(FN_POP_REAR, '0);
    issue_request(FN_PEEK_REAR, '0);

    cap_plan = '{5'd0, 5'd1, 5'd31, 5'd17, 5'd3, 5'd16, 5'd0, 5'd0};
    cap_plan[6] = 5'($urandom_range(2, 16));
    cap_plan[7] = 5'($urandom);
    foreach (cap_plan[p]) begin
      write_capacity(cap_plan[p]);
      pacing_on = (p != 5);
      random_requests(40, 65, 20);
      random_requests(30, 20, 65);
      random_requests(30, 40, 40);
    end
    pacing_on = 1'b1;

    drain_and_settle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
